@@ design/idf_pkg.sv @@
// ----------------------------------------------------------------------------
// idf_pkg
// Shared types and constants for the identity document frame decoder.
// ----------------------------------------------------------------------------
package idf_pkg;

  localparam int unsigned CountW = 17;

  localparam logic [CountW-1:0] SEQ_START    = 17'd33;
  localparam logic [CountW-1:0] EXPIRY_START = 17'd41;
  localparam logic [CountW-1:0] LENGTH_START = 17'd49;
  localparam logic [CountW-1:0] PREFIX_BYTES = 17'd51;
  localparam logic [CountW-1:0] SIG_BYTES    = 17'd64;
  localparam logic [CountW-1:0] MIN_FRAME    = PREFIX_BYTES + SIG_BYTES;
  localparam logic [CountW-1:0] COUNT_MAX    = 17'h1FFFF;
  localparam logic [15:0]       OFFSET_MAX   = 16'hFFFF;
  localparam logic [7:0]        VERSION_RESET = 8'd1;

  typedef enum logic [2:0] {
    KIND_VERSION = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_SEQ     = 3'd2,
    KIND_EXPIRY  = 3'd3,
    KIND_LENGTH  = 3'd4,
    KIND_BODY    = 3'd5,
    KIND_SIG     = 3'd6
  } field_kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_BAD_VER    = 3'd3,
    ST_LEN_MISMATCH = 3'd4
  } status_e;

  typedef struct packed {
    field_kind_e kind;
    logic [15:0] offset;
  } tag_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] seq;
    logic [63:0] expiry;
    logic [15:0] length;
  } summary_t;

endpackage

@@ design/idf_field_tag.sv @@
// ----------------------------------------------------------------------------
// idf_field_tag
// Maps the byte position within the frame to its field and field offset.
// ----------------------------------------------------------------------------
module idf_field_tag (
  input  logic [idf_pkg::CountW-1:0] pos_i,
  input  logic [15:0]                body_size_i,
  output idf_pkg::tag_t              tag_o
);

  logic [idf_pkg::CountW-1:0] body_end;
  logic [idf_pkg::CountW-1:0] key_off;
  logic [idf_pkg::CountW-1:0] seq_off;
  logic [idf_pkg::CountW-1:0] exp_off;
  logic [idf_pkg::CountW-1:0] len_off;
  logic [idf_pkg::CountW-1:0] body_off;
  logic [idf_pkg::CountW-1:0] sig_off;

  assign body_end = idf_pkg::PREFIX_BYTES + {1'b0, body_size_i};
  assign key_off  = pos_i - 17'd1;
  assign seq_off  = pos_i - idf_pkg::SEQ_START;
  assign exp_off  = pos_i - idf_pkg::EXPIRY_START;
  assign len_off  = pos_i - idf_pkg::LENGTH_START;
  assign body_off = pos_i - idf_pkg::PREFIX_BYTES;
  assign sig_off  = pos_i - body_end;

  always_comb begin
    if (pos_i == '0) begin
      tag_o.kind   = idf_pkg::KIND_VERSION;
      tag_o.offset = '0;
    end else if (pos_i < idf_pkg::SEQ_START) begin
      tag_o.kind   = idf_pkg::KIND_KEY;
      tag_o.offset = key_off[15:0];
    end else if (pos_i < idf_pkg::EXPIRY_START) begin
      tag_o.kind   = idf_pkg::KIND_SEQ;
      tag_o.offset = seq_off[15:0];
    end else if (pos_i < idf_pkg::LENGTH_START) begin
      tag_o.kind   = idf_pkg::KIND_EXPIRY;
      tag_o.offset = exp_off[15:0];
    end else if (pos_i < idf_pkg::PREFIX_BYTES) begin
      tag_o.kind   = idf_pkg::KIND_LENGTH;
      tag_o.offset = len_off[15:0];
    end else if (pos_i < body_end) begin
      tag_o.kind   = idf_pkg::KIND_BODY;
      tag_o.offset = body_off[15:0];
    end else begin
      tag_o.kind   = idf_pkg::KIND_SIG;
      tag_o.offset = sig_off[16] ? idf_pkg::OFFSET_MAX : sig_off[15:0];
    end
  end

endmodule

@@ design/idf_frame_state.sv @@
// ----------------------------------------------------------------------------
// idf_frame_state
// Per-frame byte count, version flag and field accumulators; frame status.
// ----------------------------------------------------------------------------
module idf_frame_state #(
  parameter int unsigned MAX_DOC_BYTES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [7:0]                 byte_i,
  input  logic                       last_i,
  input  logic [7:0]                 exp_version_i,
  input  idf_pkg::tag_t              tag_i,
  output logic [idf_pkg::CountW-1:0] pos_o,
  output logic [15:0]                body_size_o,
  output idf_pkg::summary_t          summary_o
);

  logic [idf_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic                       ver_ok_q, ver_ok_d, ver_upd;
  logic [63:0]                seq_q, seq_d, seq_upd;
  logic [63:0]                exp_q, exp_d, exp_upd;
  logic [15:0]                len_q, len_d, len_upd;
  logic [5:0]                 shift;
  idf_pkg::status_e           status;

  assign shift     = {tag_i.offset[2:0], 3'b000};
  assign count_inc = (count_q == idf_pkg::COUNT_MAX) ? count_q : count_q + 17'd1;

  always_comb begin
    ver_upd = ver_ok_q;
    seq_upd = seq_q;
    exp_upd = exp_q;
    len_upd = len_q;
    case (tag_i.kind)
      idf_pkg::KIND_VERSION: ver_upd = (byte_i == exp_version_i);
      idf_pkg::KIND_SEQ:     seq_upd[shift +: 8] = seq_q[shift +: 8] | byte_i;
      idf_pkg::KIND_EXPIRY:  exp_upd[shift +: 8] = exp_q[shift +: 8] | byte_i;
      idf_pkg::KIND_LENGTH: begin
        if (tag_i.offset[0]) begin
          len_upd[15:8] = len_q[15:8] | byte_i;
        end else begin
          len_upd[7:0] = len_q[7:0] | byte_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (count_inc < idf_pkg::MIN_FRAME) begin
      status = idf_pkg::ST_TOO_SHORT;
    end else if (count_inc > idf_pkg::CountW'(MAX_DOC_BYTES)) begin
      status = idf_pkg::ST_TOO_LONG;
    end else if (!ver_upd) begin
      status = idf_pkg::ST_BAD_VER;
    end else if (count_inc != idf_pkg::MIN_FRAME + {1'b0, len_upd}) begin
      status = idf_pkg::ST_LEN_MISMATCH;
    end else begin
      status = idf_pkg::ST_OK;
    end
  end

  always_comb begin
    if (last_i) begin
      summary_o.status = status;
      summary_o.seq    = seq_upd;
      summary_o.expiry = exp_upd;
      summary_o.length = len_upd;
      count_d  = '0;
      ver_ok_d = 1'b0;
      seq_d    = '0;
      exp_d    = '0;
      len_d    = '0;
    end else begin
      summary_o.status = idf_pkg::ST_OK;
      summary_o.seq    = '0;
      summary_o.expiry = '0;
      summary_o.length = '0;
      count_d  = count_inc;
      ver_ok_d = ver_upd;
      seq_d    = seq_upd;
      exp_d    = exp_upd;
      len_d    = len_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ver_ok_q <= 1'b0;
      seq_q    <= '0;
      exp_q    <= '0;
      len_q    <= '0;
    end else if (take_i) begin
      count_q  <= count_d;
      ver_ok_q <= ver_ok_d;
      seq_q    <= seq_d;
      exp_q    <= exp_d;
      len_q    <= len_d;
    end
  end

  assign pos_o       = count_q;
  assign body_size_o = len_q;

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> count_q == '0 && seq_q == '0 && len_q == '0)
    else $error("frame state not cleared after last word");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !last_i |=> count_q != '0)
    else $error("byte count did not advance");

  a_count_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !last_i && count_q == idf_pkg::COUNT_MAX |=>
      count_q == idf_pkg::COUNT_MAX)
    else $error("byte count left its saturation value");
`endif

endmodule

@@ design/identity_doc_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// identity_doc_frame_decoder
// Tags each frame word with its field and offset; reports status at frame end.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry byte_value_i and last_byte_i,
// one frame byte per word. Output channel: out_valid_o / out_stall_i carry
// the tagged byte, frame_end, status and the assembled seq, expiry and body
// length (status and summary are zero unless frame_end is set).
// Config channel: cfg_valid_i / cfg_ready_o write expected_version from
// cfg_data_i; write it only while no frame word is in flight.
// A word accepted is registered in the single output register stage and shown
// on the output in the next cycle. Throughput: one word per cycle unless the
// receiver stalls; per-frame state updates in the same cycle as the accept.
// When the receiver stalls with a word held, in_stall_o rises in the same
// cycle and the held word stays unchanged until taken.
// Reset clears the frame state, empties the output register and sets
// expected_version to 1.
// ----------------------------------------------------------------------------
module identity_doc_frame_decoder #(
  parameter int unsigned MAX_DOC_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  field_kind_o,
  output logic [15:0] field_offset_o,
  output logic [7:0]  byte_out_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [63:0] seq_number_o,
  output logic [63:0] expiry_time_o,
  output logic [15:0] body_length_o
);

  logic                       take;
  logic [7:0]                 exp_version_q;
  logic [idf_pkg::CountW-1:0] pos;
  logic [15:0]                body_size;
  idf_pkg::tag_t              tag;
  idf_pkg::summary_t          summary;

  logic                       out_valid_q;
  idf_pkg::tag_t              tag_q;
  logic [7:0]                 byte_q;
  logic                       end_q;
  idf_pkg::summary_t          summary_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign take        = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= idf_pkg::VERSION_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_version_q <= cfg_data_i;
    end
  end

  idf_field_tag u_tag (
    .pos_i       (pos),
    .body_size_i (body_size),
    .tag_o       (tag)
  );

  idf_frame_state #(
    .MAX_DOC_BYTES (MAX_DOC_BYTES)
  ) u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .byte_i        (byte_value_i),
    .last_i        (last_byte_i),
    .exp_version_i (exp_version_q),
    .tag_i         (tag),
    .pos_o         (pos),
    .body_size_o   (body_size),
    .summary_o     (summary)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tag_q     <= tag;
      byte_q    <= byte_value_i;
      end_q     <= last_byte_i;
      summary_q <= summary;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_kind_o   = tag_q.kind;
  assign field_offset_o = tag_q.offset;
  assign byte_out_o     = byte_q;
  assign frame_end_o    = end_q;
  assign status_o       = summary_q.status;
  assign seq_number_o   = summary_q.seq;
  assign expiry_time_o  = summary_q.expiry;
  assign body_length_o  = summary_q.length;

`ifndef SYNTHESIS
  a_summary_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !end_q |-> summary_q.status == idf_pkg::ST_OK &&
      summary_q.length == '0 && summary_q.seq == '0)
    else $error("summary set on a word that does not end the frame");

  a_ok_ends_in_sig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_q && summary_q.status == idf_pkg::ST_OK |->
      tag_q.kind == idf_pkg::KIND_SIG)
    else $error("good frame ended outside the signature");

  a_version_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tag_q.kind == idf_pkg::KIND_VERSION |-> tag_q.offset == '0)
    else $error("version word with nonzero offset");
`endif

endmodule

@@ verif/tb_identity_doc_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_identity_doc_frame_decoder
// Self-checking bench for the document frame decoder. A queue of frame words
// feeds a bursty driver while the receiver stalls on a changing pattern. Each
// accepted word is run through a local decoder that tracks field position,
// version match and the seq, expiry and length fields. Every output word is
// compared with the oldest decoded word. Directed frames cover a minimal good
// frame, one-word frames, a short frame ending in the seq field and a bad
// version in a short frame. Random frames use several expected_version settings.
// ----------------------------------------------------------------------------
module tb_identity_doc_frame_decoder;

  localparam int unsigned MaxDocBytes = 1024;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned ShowLimit   = 10;
  localparam int unsigned ItemTarget  = 500;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_word_t;

  typedef struct packed {
    idf_pkg::field_kind_e kind;
    logic [15:0]          offset;
    logic [7:0]           value;
    logic                 frame_end;
    idf_pkg::status_e     status;
    logic [63:0]          seq;
    logic [63:0]          expiry;
    logic [15:0]          length;
  } decoded_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  field_kind_o;
  logic [15:0] field_offset_o;
  logic [7:0]  byte_out_o;
  logic        frame_end_o;
  logic [2:0]  status_o;
  logic [63:0] seq_number_o;
  logic [63:0] expiry_time_o;
  logic [15:0] body_length_o;

  frame_word_t   pending_words[$];
  decoded_word_t decoded_q[$];
  decoded_word_t exp_w;

  logic [7:0]  want_version = idf_pkg::VERSION_RESET;
  int unsigned frame_count = 0;
  logic        ver_match = 1'b0;
  logic [63:0] seq_acc = '0;
  logic [63:0] expiry_acc = '0;
  logic [15:0] len_acc = '0;

  int unsigned errors = 0;
  int unsigned queued_words = 0;
  int unsigned sent_words = 0;
  int unsigned checked_words = 0;
  int unsigned frames_done = 0;
  int unsigned versions_set = 0;
  int unsigned status_hits[5] = '{default: 0};

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  logic [7:0]  stall_tick = '0;
  logic        stall_hold = 1'b0;
  logic        stall_next;
  int unsigned idle_cycles = 0;

  identity_doc_frame_decoder #(
    .MAX_DOC_BYTES(MaxDocBytes)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_kind_o   (field_kind_o),
    .field_offset_o (field_offset_o),
    .byte_out_o     (byte_out_o),
    .frame_end_o    (frame_end_o),
    .status_o       (status_o),
    .seq_number_o   (seq_number_o),
    .expiry_time_o  (expiry_time_o),
    .body_length_o  (body_length_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic decode_word(input frame_word_t w);
    decoded_word_t d;
    int unsigned pos;
    int unsigned off;
    d = '0;
    pos = frame_count;
    d.value = w.value;
    d.frame_end = w.last;
    if (pos == 0) begin
      d.kind = idf_pkg::KIND_VERSION;
      off = 0;
      ver_match = (w.value == want_version);
    end else if (pos < idf_pkg::SEQ_START) begin
      d.kind = idf_pkg::KIND_KEY;
      off = pos - 1;
    end else if (pos < idf_pkg::EXPIRY_START) begin
      d.kind = idf_pkg::KIND_SEQ;
      off = pos - idf_pkg::SEQ_START;
      seq_acc = seq_acc | (64'(w.value) << (8 * off));
    end else if (pos < idf_pkg::LENGTH_START) begin
      d.kind = idf_pkg::KIND_EXPIRY;
      off = pos - idf_pkg::EXPIRY_START;
      expiry_acc = expiry_acc | (64'(w.value) << (8 * off));
    end else if (pos < idf_pkg::PREFIX_BYTES) begin
      d.kind = idf_pkg::KIND_LENGTH;
      off = pos - idf_pkg::LENGTH_START;
      len_acc = len_acc | 16'(32'(w.value) << (8 * off));
    end else if (pos < idf_pkg::PREFIX_BYTES + len_acc) begin
      d.kind = idf_pkg::KIND_BODY;
      off = pos - idf_pkg::PREFIX_BYTES;
    end else begin
      d.kind = idf_pkg::KIND_SIG;
      off = pos - idf_pkg::PREFIX_BYTES - len_acc;
      if (off > idf_pkg::OFFSET_MAX) off = idf_pkg::OFFSET_MAX;
    end
    d.offset = off[15:0];
    if (frame_count < idf_pkg::COUNT_MAX) frame_count++;
    if (w.last) begin
      if (frame_count < idf_pkg::MIN_FRAME) d.status = idf_pkg::ST_TOO_SHORT;
      else if (frame_count > MaxDocBytes) d.status = idf_pkg::ST_TOO_LONG;
      else if (!ver_match) d.status = idf_pkg::ST_BAD_VER;
      else if (frame_count != idf_pkg::PREFIX_BYTES + len_acc + idf_pkg::SIG_BYTES)
        d.status = idf_pkg::ST_LEN_MISMATCH;
      else d.status = idf_pkg::ST_OK;
      d.seq = seq_acc;
      d.expiry = expiry_acc;
      d.length = len_acc;
      status_hits[d.status]++;
      frames_done++;
      frame_count = 0;
      ver_match = 1'b0;
      seq_acc = '0;
      expiry_acc = '0;
      len_acc = '0;
    end
    decoded_q.push_back(d);
  endtask

  task automatic push_frame(input logic [7:0] ver, input logic [15:0] len_field,
                            input int unsigned total, input fill_e fill);
    frame_word_t w;
    for (int unsigned i = 0; i < total; i++) begin
      case (fill)
        FILL_ZERO: w.value = 8'h00;
        FILL_ONES: w.value = 8'hFF;
        default:   w.value = 8'($urandom);
      endcase
      if (i == 0) w.value = ver;
      else if (i == idf_pkg::LENGTH_START) w.value = len_field[7:0];
      else if (i == idf_pkg::LENGTH_START + 1) w.value = len_field[15:8];
      w.last = (i == total - 1);
      pending_words.push_back(w);
    end
    queued_words += total;
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_version(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    want_version = v;
    versions_set++;
  endtask

  // sender: bursts of words with random gaps, hold while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_word(pending_words.pop_front());
        sent_words++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_valid_i   <= 1'b1;
          byte_value_i <= pending_words[0].value;
          last_byte_i  <= pending_words[0].last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern is picked anew each time the 8-bit stall_tick wraps
  always @(posedge clk_i) begin
    if (stall_tick == 8'd0) stall_mode = $urandom_range(0, 4);
    stall_tick = stall_tick + 8'd1;
    case (stall_mode)
      0: stall_next = 1'b0;
      1: stall_next = ($urandom_range(0, 3) == 0);
      2: stall_next = ($urandom_range(0, 9) < 6);
      3: stall_next = (stall_tick[1:0] == 2'd3);
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 10);
          stall_hold = ~stall_hold;
        end
        stall_run--;
        stall_next = stall_hold;
      end
    endcase
    out_stall_i <= stall_next;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_words++;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= ShowLimit)
          $display("unexpected word: kind %0d off %0d byte %02h end %0b st %0d",
                   field_kind_o, field_offset_o, byte_out_o, frame_end_o, status_o);
      end else begin
        exp_w = decoded_q.pop_front();
        if (field_kind_o !== exp_w.kind || field_offset_o !== exp_w.offset ||
            byte_out_o !== exp_w.value || frame_end_o !== exp_w.frame_end ||
            status_o !== exp_w.status || seq_number_o !== exp_w.seq ||
            expiry_time_o !== exp_w.expiry || body_length_o !== exp_w.length) begin
          errors++;
          if (errors <= ShowLimit) begin
            $display("word %0d exp: kind %0d off %0d byte %02h end %0b st %0d %h %h %h",
                     checked_words, exp_w.kind, exp_w.offset, exp_w.value,
                     exp_w.frame_end, exp_w.status, exp_w.seq, exp_w.expiry,
                     exp_w.length);
            $display("word %0d got: kind %0d off %0d byte %02h end %0b st %0d %h %h %h",
                     checked_words, field_kind_o, field_offset_o, byte_out_o,
                     frame_end_o, status_o, seq_number_o, expiry_time_o,
                     body_length_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles", IdleLimit);
      $display("tb_identity_doc_frame_decoder: done, errors");
      $finish;
    end
  end

  initial begin
    logic [7:0]  phase_version[4];
    logic [7:0]  bad_ver;
    int unsigned base_items;
    int unsigned goal;
    int unsigned body;
    int unsigned total;
    phase_version[0] = 8'h00;
    phase_version[1] = 8'hFF;
    phase_version[2] = 8'($urandom_range(2, 254));
    phase_version[3] = 8'($urandom_range(2, 254));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_frame(idf_pkg::VERSION_RESET, 16'd0, idf_pkg::MIN_FRAME, FILL_ZERO);
    push_frame(idf_pkg::VERSION_RESET, 16'd0, 1, FILL_RAND);
    push_frame(8'h07, 16'd0, 1, FILL_RAND);
    push_frame(idf_pkg::VERSION_RESET, 16'd0, idf_pkg::SEQ_START + 4, FILL_ONES);
    push_frame(8'h07, 16'd0, 60, FILL_RAND);
    base_items = queued_words;

    for (int p = 0; p < 4; p++) begin
      drain();
      set_version(phase_version[p]);
      goal = base_items + (ItemTarget - base_items) * (p + 1) / 4;
      while (queued_words < goal) begin
        body = $urandom_range(0, 20);
        bad_ver = want_version ^ (8'h01 << $urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            total = idf_pkg::MIN_FRAME + body;
            push_frame(want_version, 16'(body), total, FILL_RAND);
          end
          6: begin
            total = idf_pkg::MIN_FRAME + $urandom_range(0, 40);
            push_frame(want_version, 16'($urandom_range(0, 40)), total, FILL_RAND);
          end
          7: begin
            total = idf_pkg::MIN_FRAME + body;
            push_frame(bad_ver, 16'(body), total, FILL_RAND);
          end
          8: begin
            total = $urandom_range(1, 60);
            push_frame(8'($urandom), 16'($urandom), total, FILL_RAND);
          end
          default: begin
            total = $urandom_range(1, 150);
            push_frame(want_version, 16'($urandom), total, FILL_RAND);
          end
        endcase
      end
    end

    drain();
    $display("sent %0d words, checked %0d with %0d mismatches, %0d frames, %0d version writes",
             sent_words, checked_words, errors, frames_done, versions_set);
    $display("status ok %0d, short %0d, long %0d, bad version %0d, len mismatch %0d",
             status_hits[idf_pkg::ST_OK], status_hits[idf_pkg::ST_TOO_SHORT],
             status_hits[idf_pkg::ST_TOO_LONG], status_hits[idf_pkg::ST_BAD_VER],
             status_hits[idf_pkg::ST_LEN_MISMATCH]);
    if (errors == 0) begin
      $display("tb_identity_doc_frame_decoder: done, clean");
    end else begin
      $display("tb_identity_doc_frame_decoder: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/idf_pkg.sv
design/idf_field_tag.sv
design/idf_frame_state.sv
design/identity_doc_frame_decoder.sv
verif/tb_identity_doc_frame_decoder.sv
